// ===== rtl/tlsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsr_pkg
// Shared types, constants and helper functions of the thick line and square
// rasterizer: item and pixel layouts, line walker state, brush offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsr_pkg;

  // Stream widths, padded to whole bytes
  localparam int InDataW  = 120;
  localparam int OutDataW = 56;

  // Clip limit cap and brush cap
  localparam int MaxDim   = 4096;
  localparam int MaxBrush = 63;

  // Command codes carried in the slave tuser
  typedef enum logic [1:0] {
    FUNC_STEP   = 2'd0,
    FUNC_LINE   = 2'd1,
    FUNC_SQUARE = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  // Drawing phase: fill rectangle, then the six lines of a square
  typedef enum logic [2:0] {
    PH_FILL   = 3'd0,
    PH_TOP    = 3'd1,
    PH_BOTTOM = 3'd2,
    PH_LEFT   = 3'd3,
    PH_RIGHT  = 3'd4,
    PH_DIAG_A = 3'd5,
    PH_DIAG_B = 3'd6
  } phase_e;

  typedef logic signed [12:0] in_coord_t;
  typedef logic signed [13:0] coord_t;
  typedef logic signed [14:0] wide_t;
  typedef logic signed [15:0] delta_t;
  typedef logic signed [17:0] err_t;
  typedef logic signed [6:0]  bofs_t;
  typedef logic [5:0]         brush_t;
  typedef logic [11:0]        side_t;
  typedef logic [23:0]        color_t;
  typedef logic [12:0]        dim_t;

  // One input item
  typedef struct packed {
    func_e     func;
    in_coord_t x_start;
    in_coord_t y_start;
    in_coord_t x_end;
    in_coord_t y_end;
    side_t     side;
    brush_t    brush_size;
    color_t    line_color;
    color_t    area_color;
    logic      fill_enable;
  } item_t;

  // One pixel write
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   write_enable;
    logic   last;
  } pixel_t;

  // Line walker state
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t end_x;
    coord_t end_y;
    delta_t delta_x;
    delta_t delta_y;
    logic   step_x_neg;
    logic   step_y_neg;
    err_t   error_term;
    bofs_t  brush_dx;
    bofs_t  brush_dy;
  } line_t;

  // Segment endpoints
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } seg_t;

  // First brush offset: -(b/2)
  function automatic bofs_t brush_lo(input brush_t b);
    return -bofs_t'({2'b00, b[5:1]});
  endfunction

  // Brush offset bound: (b+1)/2
  function automatic bofs_t brush_hi(input brush_t b);
    logic [6:0] sum;
    sum = {1'b0, b} + 7'd1;
    return bofs_t'({1'b0, sum[6:1]});
  endfunction

  // Segment of a square for a given phase
  function automatic seg_t square_seg(input phase_e p, input coord_t a, input coord_t b,
                                      input coord_t c, input coord_t d);
    seg_t s;
    case (p)
      PH_TOP:    s = '{x0: a, y0: b, x1: c, y1: b};
      PH_BOTTOM: s = '{x0: a, y0: d, x1: c, y1: d};
      PH_LEFT:   s = '{x0: a, y0: b, x1: a, y1: d};
      PH_RIGHT:  s = '{x0: c, y0: b, x1: c, y1: d};
      PH_DIAG_A: s = '{x0: a, y0: b, x1: c, y1: d};
      default:   s = '{x0: a, y0: d, x1: c, y1: b};
    endcase
    return s;
  endfunction

  // Line walker setup for a segment
  function automatic line_t load_line(input seg_t s, input bofs_t blo);
    line_t  l;
    delta_t ax;
    delta_t ay;
    ax = (s.x1 > s.x0) ? (delta_t'(s.x1) - delta_t'(s.x0)) : (delta_t'(s.x0) - delta_t'(s.x1));
    ay = (s.y1 > s.y0) ? (delta_t'(s.y1) - delta_t'(s.y0)) : (delta_t'(s.y0) - delta_t'(s.y1));
    l.cur_x      = s.x0;
    l.cur_y      = s.y0;
    l.end_x      = s.x1;
    l.end_y      = s.y1;
    l.delta_x    = ax;
    l.delta_y    = -ay;
    l.step_x_neg = !(s.x0 < s.x1);
    l.step_y_neg = !(s.y0 < s.y1);
    l.error_term = err_t'(ax) - err_t'(ay);
    l.brush_dx   = blo;
    l.brush_dy   = blo;
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlsr_in_reg.sv =====
// ----------------------------------------------------------------------------
// tlsr_in_reg
// Input register of the rasterizer: captures one stream transfer and unpacks
// the command fields for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_in_reg (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [tlsr_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire  [1:0]                    s_axis_tuser,
  output logic                          item_valid_o,
  output tlsr_pkg::item_t               item_o,
  input  wire                           item_take_i
);
  import tlsr_pkg::*;

  logic                 valid_q, valid_d;
  logic [InDataW-1:0]   data_q;
  logic [1:0]           user_q;

  // Free when empty or when the core takes the held item
  assign s_axis_tready = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data_q <= s_axis_tdata;
      user_q <= s_axis_tuser;
    end
  end

  // Field unpack, lowest field first
  assign item_valid_o        = valid_q;
  assign item_o.func         = func_e'(user_q);
  assign item_o.x_start      = in_coord_t'(data_q[12:0]);
  assign item_o.y_start      = in_coord_t'(data_q[25:13]);
  assign item_o.x_end        = in_coord_t'(data_q[38:26]);
  assign item_o.y_end        = in_coord_t'(data_q[51:39]);
  assign item_o.side         = data_q[63:52];
  assign item_o.brush_size   = data_q[69:64];
  assign item_o.line_color   = data_q[93:70];
  assign item_o.area_color   = data_q[117:94];
  assign item_o.fill_enable  = data_q[118];

  // Pad bit is unused
  logic unused_pad;
  assign unused_pad = data_q[119];

endmodule

`default_nettype wire

// ===== rtl/tlsr_core.sv =====
// ----------------------------------------------------------------------------
// tlsr_core
// Command state, fill and Bresenham walker with square brush, clipping and
// the pixel output register. One item is processed per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  input  tlsr_pkg::item_t     item_i,
  output logic                item_take_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire                 cfg_index_i,
  input  wire  [12:0]         cfg_data_i,
  output logic                pix_valid_o,
  output tlsr_pkg::pixel_t    pix_o,
  input  wire                 pix_ready_i
);
  import tlsr_pkg::*;

  // Control state
  logic    busy_q, busy_d;
  phase_e  phase_q, phase_d;
  logic    is_square_q, is_square_d;
  logic    out_valid_q, out_valid_d;
  dim_t    width_q, width_d;
  dim_t    height_q, height_d;

  // Command payload state
  line_t   line_q, line_d;
  coord_t  lo_x_q, lo_x_d, lo_y_q, lo_y_d;
  coord_t  hi_x_q, hi_x_d, hi_y_q, hi_y_d;
  brush_t  brush_q, brush_d;
  color_t  lcol_q, lcol_d, fcol_q, fcol_d;
  pixel_t  pix_q, pix_d;

  // Working signals
  logic    fire;
  logic    emit;
  logic    load_en;
  seg_t    load_seg;
  brush_t  b_cap;
  bofs_t   bhi;
  bofs_t   bdx_inc, bdy_inc;
  coord_t  nx, ny;
  coord_t  new_hi_x, new_hi_y;
  wide_t   px, py;
  color_t  color;
  logic    last;
  logic    e2_x, e2_y;
  logic signed [18:0] e2;
  phase_e  phase_nxt;
  dim_t    wlim, hlim;

  // Item processed when the output slot frees up this cycle
  assign fire        = item_valid_i && (!out_valid_q || pix_ready_i);
  assign item_take_o = fire;
  assign cfg_ready_o = 1'b1;

  // Brush cap and brush offset bound of the held brush
  assign b_cap = (int'(item_i.brush_size) > MaxBrush) ? brush_t'(MaxBrush) : item_i.brush_size;
  assign bhi   = brush_hi(brush_q);

  // Square far corners, inset by the brush
  assign new_hi_x = coord_t'(item_i.x_start) + coord_t'({1'b0, item_i.side})
                  - coord_t'({1'b0, b_cap});
  assign new_hi_y = coord_t'(item_i.y_start) + coord_t'({1'b0, item_i.side})
                  - coord_t'({1'b0, b_cap});

  // Next line of a square
  always_comb begin
    case (phase_q)
      PH_TOP:    phase_nxt = PH_BOTTOM;
      PH_BOTTOM: phase_nxt = PH_LEFT;
      PH_LEFT:   phase_nxt = PH_RIGHT;
      PH_RIGHT:  phase_nxt = PH_DIAG_A;
      default:   phase_nxt = PH_DIAG_B;
    endcase
  end

  // Walker step terms
  assign bdx_inc = line_q.brush_dx + bofs_t'(1);
  assign bdy_inc = line_q.brush_dy + bofs_t'(1);
  assign nx      = line_q.cur_x + coord_t'(1);
  assign ny      = line_q.cur_y + coord_t'(1);
  assign e2      = $signed({line_q.error_term, 1'b0});
  assign e2_x    = e2 >= line_q.delta_y;
  assign e2_y    = e2 <= line_q.delta_x;

  // Command and walker next state
  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    is_square_d = is_square_q;
    line_d      = line_q;
    lo_x_d      = lo_x_q;
    lo_y_d      = lo_y_q;
    hi_x_d      = hi_x_q;
    hi_y_d      = hi_y_q;
    brush_d     = brush_q;
    lcol_d      = lcol_q;
    fcol_d      = fcol_q;
    load_en     = 1'b0;
    load_seg    = '0;
    emit        = 1'b0;
    px          = '0;
    py          = '0;
    color       = lcol_q;
    last        = 1'b0;

    if (fire) begin
      case (item_i.func) inside
        FUNC_LINE, FUNC_SQUARE: begin
          brush_d = b_cap;
          lcol_d  = item_i.line_color;
          fcol_d  = item_i.area_color;
          busy_d  = 1'b0;
          if (b_cap != '0) begin
            if (item_i.func == FUNC_LINE) begin
              is_square_d = 1'b0;
              phase_d     = PH_TOP;
              load_en     = 1'b1;
              load_seg    = '{x0: coord_t'(item_i.x_start), y0: coord_t'(item_i.y_start),
                              x1: coord_t'(item_i.x_end),   y1: coord_t'(item_i.y_end)};
              busy_d      = 1'b1;
            end else if (item_i.side != '0) begin
              is_square_d = 1'b1;
              lo_x_d      = coord_t'(item_i.x_start);
              lo_y_d      = coord_t'(item_i.y_start);
              hi_x_d      = new_hi_x;
              hi_y_d      = new_hi_y;
              if (item_i.fill_enable && (new_hi_x >= coord_t'(item_i.x_start))
                  && (new_hi_y >= coord_t'(item_i.y_start))) begin
                phase_d      = PH_FILL;
                line_d.cur_x = coord_t'(item_i.x_start);
                line_d.cur_y = coord_t'(item_i.y_start);
              end else begin
                phase_d  = PH_TOP;
                load_en  = 1'b1;
                load_seg = square_seg(PH_TOP, coord_t'(item_i.x_start),
                                      coord_t'(item_i.y_start), new_hi_x, new_hi_y);
              end
              busy_d = 1'b1;
            end
          end
        end
        FUNC_STEP: begin
          if (busy_q) begin
            emit = 1'b1;
            if (is_square_q && (phase_q == PH_FILL)) begin
              // Fill rectangle, rows outer
              px    = wide_t'(line_q.cur_x);
              py    = wide_t'(line_q.cur_y);
              color = fcol_q;
              if (nx > hi_x_q) begin
                line_d.cur_x = lo_x_q;
                if (ny > hi_y_q) begin
                  phase_d  = PH_TOP;
                  load_en  = 1'b1;
                  load_seg = square_seg(PH_TOP, lo_x_q, lo_y_q, hi_x_q, hi_y_q);
                end else begin
                  line_d.cur_y = ny;
                end
              end else begin
                line_d.cur_x = nx;
              end
            end else begin
              // Brush pixel, then brush or path advance
              px    = wide_t'(line_q.cur_x) + wide_t'(line_q.brush_dx);
              py    = wide_t'(line_q.cur_y) + wide_t'(line_q.brush_dy);
              color = lcol_q;
              if (bdy_inc < bhi) begin
                line_d.brush_dy = bdy_inc;
              end else begin
                line_d.brush_dy = brush_lo(brush_q);
                if (bdx_inc < bhi) begin
                  line_d.brush_dx = bdx_inc;
                end else begin
                  line_d.brush_dx = brush_lo(brush_q);
                  if ((line_q.cur_x == line_q.end_x) && (line_q.cur_y == line_q.end_y)) begin
                    if (!is_square_q || (phase_q == PH_DIAG_B)) begin
                      busy_d = 1'b0;
                      last   = 1'b1;
                    end else begin
                      phase_d  = phase_nxt;
                      load_en  = 1'b1;
                      load_seg = square_seg(phase_nxt, lo_x_q, lo_y_q, hi_x_q, hi_y_q);
                    end
                  end else begin
                    line_d.error_term = line_q.error_term
                                      + (e2_x ? err_t'(line_q.delta_y) : err_t'(0))
                                      + (e2_y ? err_t'(line_q.delta_x) : err_t'(0));
                    if (e2_x) begin
                      line_d.cur_x = line_q.step_x_neg ? (line_q.cur_x - coord_t'(1))
                                                       : (line_q.cur_x + coord_t'(1));
                    end
                    if (e2_y) begin
                      line_d.cur_y = line_q.step_y_neg ? (line_q.cur_y - coord_t'(1))
                                                       : (line_q.cur_y + coord_t'(1));
                    end
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    // New segment starts at the first brush offset of the held brush
    if (load_en) begin
      line_d = load_line(load_seg, brush_lo(brush_d));
    end
  end

  // Clip limits, capped
  assign wlim = (width_q  > dim_t'(MaxDim)) ? dim_t'(MaxDim) : width_q;
  assign hlim = (height_q > dim_t'(MaxDim)) ? dim_t'(MaxDim) : height_q;

  // Output register next value
  always_comb begin
    out_valid_d = out_valid_q;
    pix_d       = pix_q;
    if (emit) begin
      out_valid_d        = 1'b1;
      pix_d.pixel_x      = coord_t'(px);
      pix_d.pixel_y      = coord_t'(py);
      pix_d.pixel_color  = color;
      pix_d.write_enable = (px >= 0) && (px < $signed({2'b00, wlim}))
                        && (py >= 0) && (py < $signed({2'b00, hlim}));
      pix_d.last         = last;
    end else if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration decode
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_FILL;
      is_square_q <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= 13'd4096;
      height_q    <= 13'd4096;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      is_square_q <= is_square_d;
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    line_q  <= line_d;
    lo_x_q  <= lo_x_d;
    lo_y_q  <= lo_y_d;
    hi_x_q  <= hi_x_d;
    hi_y_q  <= hi_y_d;
    brush_q <= brush_d;
    lcol_q  <= lcol_d;
    fcol_q  <= fcol_d;
    pix_q   <= pix_d;
  end

  assign pix_valid_o = out_valid_q;
  assign pix_o       = pix_q;

endmodule

`default_nettype wire

// ===== rtl/thick_line_square_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// thick_line_square_rasterizer_unit
// Thick Bresenham line and square rasterizer with a square brush and clipping.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the command (step, start line, start square),
//   tdata the coordinates, side, brush, colors and fill enable. A start item
//   loads a command and yields no pixel; each later step item yields exactly
//   one pixel write on the master stream until the command ends, flagged by
//   tlast. tuser on the master side is the write enable (pixel inside image).
//   Configuration channel: index 0 writes image width, index 1 image height;
//   write only while idle. cfg_ready_o is always high.
//   Throughput: one item per cycle while the master side accepts. An item passes the input
//   register and the walker logic and lands in the pixel register, from which
//   its pixel is presented on the master stream.
//   The master side may stall at will: the pixel register holds its result
//   and tready drops once the input register holds an item.
//   Reset clears the command state (idle) and sets width and height to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_square_rasterizer_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Command stream
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_start, y_start, x_end, y_end, side, brush_size, line_color,
  // area_color, fill_enable, zero pad
  input  wire  [tlsr_pkg::InDataW-1:0]  s_axis_tdata,
  // func
  input  wire  [1:0]                    s_axis_tuser,
  // Pixel stream
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [tlsr_pkg::OutDataW-1:0] m_axis_tdata,
  // write_enable
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  // Configuration writes
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire                           cfg_index_i,
  input  wire  [12:0]                   cfg_data_i
);
  import tlsr_pkg::*;

  logic   item_valid;
  logic   item_take;
  item_t  item;
  pixel_t pix;

  tlsr_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  tlsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pix_valid_o  (m_axis_tvalid),
    .pix_o        (pix),
    .pix_ready_i  (m_axis_tready)
  );

  // Pixel pack, lowest field first
  assign m_axis_tdata = {4'b0000, pix.pixel_color, pix.pixel_y, pix.pixel_x};
  assign m_axis_tuser = pix.write_enable;
  assign m_axis_tlast = pix.last;

endmodule

`default_nettype wire
